// ===== hw/rtl/gfmd_pkg.sv =====
// ----------------------------------------------------------------------------
// gfmd_pkg
// Types and constant log / antilog ROMs for the GF(2^8) multiply/divide unit.
// ----------------------------------------------------------------------------
package gfmd_pkg;

  // Field polynomial x^8+x^4+x^3+x^2+1 and multiplicative group order
  localparam logic [8:0] GfPoly  = 9'h11D;
  localparam int unsigned GfOrder = 255;

  // Operation codes
  typedef enum logic {
    ACT_MUL = 1'b0,
    ACT_DIV = 1'b1
  } gfmd_act_e;

  // Input item
  typedef struct packed {
    gfmd_act_e  action;
    logic [7:0] lhs_operand;
    logic [7:0] rhs_operand;
  } gfmd_in_t;

  // Result item
  typedef struct packed {
    logic [7:0] field_result;
    logic       div_by_zero;
  } gfmd_out_t;

  // Stage 1 -> stage 2: logarithms and special-case flags
  typedef struct packed {
    gfmd_act_e  action;
    logic       zero_res;
    logic       div_by_zero;
    logic [7:0] lhs_log;
    logic [7:0] rhs_log;
  } gfmd_log_t;

  // Stage 2 -> stage 3: reduced exponent and flags
  typedef struct packed {
    logic       zero_res;
    logic       div_by_zero;
    logic [7:0] expo;
  } gfmd_exp_t;

  typedef logic [255:0][7:0] gfmd_rom_t;

  // Antilog ROM contents, entry 255 unused (zero)
  function automatic gfmd_rom_t build_alog();
    gfmd_rom_t  rom;
    logic [8:0] v;
    rom = '0;
    v   = 9'd1;
    for (int i = 0; i < GfOrder; i++) begin
      rom[i] = v[7:0];
      v = {v[7:0], 1'b0};
      if (v[8]) begin
        v = v ^ GfPoly;
      end
    end
    return rom;
  endfunction

  // Log ROM contents, entry for zero unused (zero)
  function automatic gfmd_rom_t build_log();
    gfmd_rom_t  rom;
    logic [8:0] v;
    rom = '0;
    v   = 9'd1;
    for (int i = 0; i < GfOrder; i++) begin
      rom[v[7:0]] = 8'(i);
      v = {v[7:0], 1'b0};
      if (v[8]) begin
        v = v ^ GfPoly;
      end
    end
    return rom;
  endfunction

  localparam gfmd_rom_t AlogRom = build_alog();
  localparam gfmd_rom_t LogRom  = build_log();

endpackage

// ===== hw/rtl/gfmd_log_stage.sv =====
// ----------------------------------------------------------------------------
// gfmd_log_stage
// First pipeline stage: log ROM lookup of both operands, zero/error flags.
// ----------------------------------------------------------------------------
module gfmd_log_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  gfmd_pkg::gfmd_in_t  data_i,
  output logic              valid_o,
  output gfmd_pkg::gfmd_log_t data_o
);
  import gfmd_pkg::*;

  logic      valid_q;
  gfmd_log_t data_d, data_q;

  // Lookups and special cases
  always_comb begin
    data_d.action      = data_i.action;
    data_d.zero_res    = (data_i.lhs_operand == 8'd0) || (data_i.rhs_operand == 8'd0);
    data_d.div_by_zero = (data_i.action == ACT_DIV) && (data_i.rhs_operand == 8'd0);
    data_d.lhs_log     = LogRom[data_i.lhs_operand];
    data_d.rhs_log     = LogRom[data_i.rhs_operand];
  end

  // Valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== hw/rtl/gfmd_exp_stage.sv =====
// ----------------------------------------------------------------------------
// gfmd_exp_stage
// Second pipeline stage: log sum or difference reduced modulo 255.
// ----------------------------------------------------------------------------
module gfmd_exp_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  gfmd_pkg::gfmd_log_t data_i,
  output logic               valid_o,
  output gfmd_pkg::gfmd_exp_t data_o
);
  import gfmd_pkg::*;

  localparam logic [8:0] Order9 = 9'(GfOrder);

  logic      valid_q;
  gfmd_exp_t data_d, data_q;
  logic [8:0] sum, diff, expo;

  // Logs are below 255, so one correction step is enough
  always_comb begin
    sum  = {1'b0, data_i.lhs_log} + {1'b0, data_i.rhs_log};
    diff = {1'b0, data_i.lhs_log} - {1'b0, data_i.rhs_log};
    if (data_i.action == ACT_MUL) begin
      expo = (sum >= Order9) ? (sum - Order9) : sum;
    end else begin
      expo = diff[8] ? (diff + Order9) : diff;
    end
    data_d.zero_res    = data_i.zero_res;
    data_d.div_by_zero = data_i.div_by_zero;
    data_d.expo        = expo[7:0];
  end

  // Valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== hw/rtl/gfmd_alog_stage.sv =====
// ----------------------------------------------------------------------------
// gfmd_alog_stage
// Third pipeline stage: antilog ROM lookup into the output register.
// ----------------------------------------------------------------------------
module gfmd_alog_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  gfmd_pkg::gfmd_exp_t data_i,
  output logic               valid_o,
  output gfmd_pkg::gfmd_out_t data_o
);
  import gfmd_pkg::*;

  logic      valid_q;
  gfmd_out_t data_d, data_q;

  // Zero operand or bad divide forces a zero result
  always_comb begin
    data_d.field_result = data_i.zero_res ? 8'd0 : AlogRom[data_i.expo];
    data_d.div_by_zero  = data_i.div_by_zero;
  end

  // Valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== hw/rtl/gf256_mul_div_unit_core.sv =====
// ----------------------------------------------------------------------------
// gf256_mul_div_unit_core
// Three registered stages: log lookup, exponent reduction, antilog lookup.
// Throughput: one item per cycle while results are taken; a stalled stage holds, empty stages fill.
// Reset clears all stage valid bits; the payload registers are not reset.
// GF(2^8) multiply/divide over 0x11D via log and antilog ROMs.
// ----------------------------------------------------------------------------
module gf256_mul_div_unit_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  gfmd_pkg::gfmd_in_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output gfmd_pkg::gfmd_out_t out_data_o
);
  import gfmd_pkg::*;

  logic      v1, v2, v3;
  logic      en1, en2, en3;
  gfmd_log_t s1_data;
  gfmd_exp_t s2_data;

  // A stage loads when it is empty or its item moves on
  assign en3        = !v3 || out_ready_i;
  assign en2        = !v2 || en3;
  assign en1        = !v1 || en2;
  assign in_ready_o = en1;

  gfmd_log_stage u_log (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en1),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .valid_o (v1),
    .data_o  (s1_data)
  );

  gfmd_exp_stage u_exp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en2),
    .valid_i (v1),
    .data_i  (s1_data),
    .valid_o (v2),
    .data_o  (s2_data)
  );

  gfmd_alog_stage u_alog (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en3),
    .valid_i (v2),
    .data_i  (s2_data),
    .valid_o (v3),
    .data_o  (out_data_o)
  );

  assign out_valid_o = v3;

endmodule

// ===== tb/gf256_mul_div_unit_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gf256_mul_div_unit_core_test
// Drives GF(2^8) multiply and divide items through the unit, with random
// idle bursts on both handshakes. Each accepted item is predicted from
// locally built exp/log tables over x^8+x^4+x^3+x^2+1. Each result is then
// checked field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module gf256_mul_div_unit_core_test;
  import gfmd_pkg::*;

  localparam int unsigned ClkPeriod   = 20;
  localparam int unsigned RandomItems = 1050;
  localparam int unsigned QuietItems  = 120;
  localparam int unsigned CycleLimit  = 200000;

  // Field arithmetic predictor and the queue of products / quotients in flight
  class gf_result_board;
    logic [7:0]  antilog_q [0:254];
    logic [7:0]  log_q     [0:255];
    gfmd_out_t   pending_results [$];
    int unsigned mismatches;
    int unsigned results_seen;

    function new();
      logic [7:0] elem;
      elem = 8'h01;
      foreach (log_q[i]) log_q[i] = 8'h00;
      // walk the powers of alpha; reduce by the low byte of the polynomial
      for (int i = 0; i < 255; i++) begin
        antilog_q[i] = elem;
        log_q[elem]  = 8'(i);
        elem = {elem[6:0], 1'b0} ^ (elem[7] ? 8'h1D : 8'h00);
      end
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function gfmd_out_t field_op_result(gfmd_in_t op);
      gfmd_out_t   res;
      int unsigned expo;
      res = '0;
      if (op.action == ACT_MUL) begin
        if (op.lhs_operand != 8'h00 && op.rhs_operand != 8'h00) begin
          expo = (log_q[op.lhs_operand] + log_q[op.rhs_operand]) % 255;
          res.field_result = antilog_q[expo];
        end
      end else if (op.rhs_operand == 8'h00) begin
        // divide by zero, even 0/0: zero result with the flag raised
        res.div_by_zero = 1'b1;
      end else if (op.lhs_operand != 8'h00) begin
        expo = (log_q[op.lhs_operand] + 255 - log_q[op.rhs_operand]) % 255;
        res.field_result = antilog_q[expo];
      end
      return res;
    endfunction

    function void note_operands(gfmd_in_t op);
      pending_results.push_back(field_op_result(op));
    endfunction

    task report_mismatch(string what, int unsigned got, int unsigned want);
      $display("%0t: mismatch on %s at result %0d: got %0h, want %0h",
               $time, what, results_seen, got, want);
      mismatches++;
    endtask

    task check_result(gfmd_out_t got);
      gfmd_out_t want;
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing outstanding", 32'(got), 0);
        return;
      end
      want = pending_results.pop_front();
      if (got.field_result !== want.field_result)
        report_mismatch("field_result", 32'(got.field_result), 32'(want.field_result));
      if (got.div_by_zero !== want.div_by_zero)
        report_mismatch("div_by_zero", 32'(got.div_by_zero), 32'(want.div_by_zero));
      results_seen++;
    endtask
  endclass

  logic           clk_i;
  logic           rst_ni;
  logic           in_valid;
  logic           in_ready;
  gfmd_in_t       in_data;
  logic           out_valid;
  logic           out_ready;
  gfmd_out_t      out_data;

  gf_result_board board;
  bit             tail_phase;
  int unsigned    cycle_count = 0;

  gf256_mul_div_unit_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Handshake monitor: note accepted items, check accepted results
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready) board.note_operands(in_data);
      if (out_valid && out_ready) board.check_result(out_data);
    end
  end

  // Result side back-pressure in random bursts; none in the tail
  initial begin
    out_ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    out_ready <= 1'b1;
    forever begin
      @(negedge clk_i);
      if (!tail_phase && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk_i);
        out_ready <= 1'b1;
        // occasionally a long clean stretch
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(10, 40)) @(negedge clk_i);
      end
    end
  end

  // Present one item after an optional idle burst, hold until accepted
  task drive_item(gfmd_act_e act, logic [7:0] lhs, logic [7:0] rhs);
      gfmd_in_t    item;
      int unsigned idle;
      item.action      = act;
      item.lhs_operand = lhs;
      item.rhs_operand = rhs;
      idle = (!tail_phase && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
      @(negedge clk_i);
      if (idle != 0) begin
        in_valid <= 1'b0;
        repeat (idle) @(negedge clk_i);
      end
      in_valid <= 1'b1;
      in_data  <= item;
      do @(posedge clk_i); while (!in_ready);
  endtask

  // Operands biased towards zero, one and the top element
  function automatic logic [7:0] pick_operand();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'h01;
      2:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Stimulus and end of run
  initial begin
    board       = new();
    tail_phase  = 1'b0;
    rst_ni      = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: zero operands, identities, extremes, reduction, divide errors
    drive_item(ACT_MUL, 8'h00, 8'h00);
    drive_item(ACT_MUL, 8'h00, 8'hA7);
    drive_item(ACT_MUL, 8'h5C, 8'h00);
    drive_item(ACT_MUL, 8'hFF, 8'h00);
    drive_item(ACT_MUL, 8'h01, 8'h01);
    drive_item(ACT_MUL, 8'h01, 8'hFF);
    drive_item(ACT_MUL, 8'hFF, 8'hFF);
    drive_item(ACT_MUL, 8'h80, 8'h02);
    drive_item(ACT_MUL, 8'h02, 8'h8E);
    drive_item(ACT_MUL, 8'hAA, 8'h55);
    drive_item(ACT_DIV, 8'h00, 8'h00);
    drive_item(ACT_DIV, 8'hFF, 8'h00);
    drive_item(ACT_DIV, 8'h01, 8'h00);
    drive_item(ACT_DIV, 8'h00, 8'h13);
    drive_item(ACT_DIV, 8'h00, 8'hFF);
    drive_item(ACT_DIV, 8'h37, 8'h37);
    drive_item(ACT_DIV, 8'hFF, 8'hFF);
    drive_item(ACT_DIV, 8'hFF, 8'h01);
    drive_item(ACT_DIV, 8'h01, 8'hFF);
    drive_item(ACT_DIV, 8'h01, 8'h02);
    drive_item(ACT_DIV, 8'h80, 8'hFF);
    drive_item(ACT_DIV, 8'h55, 8'hAA);

    // random part; the tail runs with no idling on either side
    for (int unsigned n = 0; n < RandomItems; n++) begin
      if (n == RandomItems - QuietItems) tail_phase = 1'b1;
      drive_item($urandom_range(0, 1) ? ACT_DIV : ACT_MUL, pick_operand(), pick_operand());
    end
    @(negedge clk_i);
    in_valid <= 1'b0;

    // drain, then idle on to catch anything stray
    while (board.pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (board.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/gfmd_pkg.sv
hw/rtl/gfmd_log_stage.sv
hw/rtl/gfmd_exp_stage.sv
hw/rtl/gfmd_alog_stage.sv
hw/rtl/gf256_mul_div_unit_core.sv
tb/gf256_mul_div_unit_core_test.sv
